FILE: src/ogcf_pkg.sv
// Shared types, constants and helper functions for the occupancy grid cell fusion block.
package ogcf_pkg;

  localparam int unsigned CellAddrW  = 12;
  localparam int unsigned CellStore  = 4096;
  localparam int unsigned ProbW      = 16;
  localparam int unsigned LevelW     = 9;
  localparam int unsigned MapW       = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned ProdW      = 34;
  localparam int unsigned QuotW      = 17;
  localparam int unsigned DivSteps   = 17;

  // Fusion mode codes
  localparam logic [1:0] ModePool  = 2'd0;
  localparam logic [1:0] ModeMax   = 2'd1;
  localparam logic [1:0] ModeLevel = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFusionMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEmptyProb  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOccProb    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEmptyInt   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOccInt     = 3'd4;

  // Reset values
  localparam logic [ProbW-1:0]         HalfProb      = 16'd32768;
  localparam logic [ProbW-1:0]         EmptyProbRst  = 16'd19661;
  localparam logic [ProbW-1:0]         OccProbRst    = 16'd45875;
  localparam logic signed [LevelW-1:0] EmptyIntRst   = -9'sd3;
  localparam logic signed [LevelW-1:0] OccIntRst     = 9'sd5;

  // Map classes
  localparam logic signed [MapW-1:0] MapEmpty   = 8'sd0;
  localparam logic signed [MapW-1:0] MapOcc     = 8'sd100;
  localparam logic signed [MapW-1:0] MapUnknown = -8'sd1;

  // Integer level results
  localparam logic signed [LevelW-1:0] LvlStep = 9'sd10;
  localparam logic signed [LevelW-1:0] LvlBoth = 9'sd220;

  typedef enum logic [1:0] {
    ClsNone  = 2'd0,
    ClsProb  = 2'd1,
    ClsLevel = 2'd2
  } cls_e;

  // Control and pass-through fields that travel the whole pipeline
  typedef struct packed {
    logic                     valid;
    logic [CellAddrW-1:0]     addr;
    cls_e                     cls;
    logic                     use_div;
    logic                     we_prob;
    logic                     we_level;
    logic [ProbW-1:0]         prob;
    logic signed [LevelW-1:0] level;
  } ctl_t;

  // Divider stage
  typedef struct packed {
    ctl_t              ctl;
    logic [ProdW-1:0]  rem;
    logic [QuotW-1:0]  nlow;
    logic [ProdW-1:0]  den;
    logic [QuotW-1:0]  quot;
  } div_t;

  // Sigmoid tail: 65536/(1+exp(k)) for k = 0..11
  function automatic logic [ProbW:0] sig_tail(input logic [3:0] k);
    logic [ProbW:0] t;
    case (k)
      4'd0:    t = 17'd32768;
      4'd1:    t = 17'd17625;
      4'd2:    t = 17'd7812;
      4'd3:    t = 17'd3108;
      4'd4:    t = 17'd1179;
      4'd5:    t = 17'd439;
      4'd6:    t = 17'd162;
      4'd7:    t = 17'd60;
      4'd8:    t = 17'd22;
      4'd9:    t = 17'd8;
      4'd10:   t = 17'd3;
      4'd11:   t = 17'd1;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

  // Reading to Q0.16 probability, clamped to 1..65535
  function automatic logic [ProbW-1:0] sigmoid(input logic signed [7:0] e);
    logic [7:0]     mag;
    logic [ProbW:0] tail;
    logic [ProbW:0] p;
    mag  = e[7] ? 8'(-e) : 8'(e);
    tail = (mag < 8'd12) ? sig_tail(mag[3:0]) : 17'd0;
    p    = e[7] ? tail : 17'd65536 - tail;
    if (p == 17'd0) return 16'd1;
    if (p > 17'd65535) return 16'd65535;
    return p[ProbW-1:0];
  endfunction

  // Min/max rule around one half
  function automatic logic [ProbW-1:0] fuse_max(input logic [ProbW-1:0] a,
                                                input logic [ProbW-1:0] b);
    if (a < HalfProb || b < HalfProb) return (a < b) ? a : b;
    if (a > HalfProb || b > HalfProb) return (a > b) ? a : b;
    return HalfProb;
  endfunction

  // Quantized integer fusion, q = 2
  function automatic logic signed [LevelW-1:0] fuse_int(input logic signed [7:0] e,
                                                         input logic signed [LevelW-1:0] l);
    logic mn, mz, mp, nn, nz, np;
    mn = e[7];
    mz = (e == 8'sd0);
    mp = !mn && !mz;
    nn = l[LevelW-1];
    nz = (l == 9'sd0);
    np = !nn && !nz;
    if (mn && nn) return -LvlBoth;
    if (mp && np) return LvlBoth;
    if ((mn && nz) || (mz && nn)) return -LvlStep;
    if ((mp && nz) || (mz && np)) return LvlStep;
    return 9'sd0;
  endfunction

endpackage

FILE: src/occupancy_grid_cell_fusion.sv
// Occupancy grid cell fusion: memory read-modify-write with pipelined opinion pool divider.
// Pipeline stages in order: read, setup, divide and out; done_o is the registered result strobe.
// Throughput: one transaction per cycle while busy is low; busy interlocks a cell still in flight, so the same
// cell is taken again only after the write-back of its previous transaction.
// Reset: asynchronous, active low; then a clearing pass over min(W*H, 4096) cells
// fills both grids while busy stays high. Config writes are taken at any time.
// Results are strobed for one cycle by done_o; the receiver cannot stall.
module occupancy_grid_cell_fusion
  import ogcf_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [CellAddrW-1:0]        cell_index_i,
  input  logic signed [7:0]           evidence_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  output logic                        done_o,
  output logic [CellAddrW-1:0]        cell_addr_out_o,
  output logic signed [MapW-1:0]      map_value_o,
  output logic [ProbW-1:0]            fused_prob_o,
  output logic signed [LevelW-1:0]    fused_level_o
);

  localparam longint unsigned Cells = longint'(GRID_WIDTH) * longint'(GRID_HEIGHT);
  localparam int unsigned Depth = (Cells < CellStore) ? int'(Cells) : CellStore;
  localparam int unsigned ClrW  = $clog2(CellStore + 1);

  typedef struct packed {
    logic                 valid;
    logic [CellAddrW-1:0] addr;
    logic                 in_range;
    logic signed [7:0]    ev;
    logic [ProbW-1:0]     pn;
  } acc_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [ProdW-1:0]  num;
    logic [ProdW-1:0]  oth;
  } prod_t;

  // Configuration registers
  logic [1:0]               mode_q;
  logic [ProbW-1:0]         empty_prob_q, occ_prob_q;
  logic signed [LevelW-1:0] empty_int_q, occ_int_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModePool;
      empty_prob_q <= EmptyProbRst;
      occ_prob_q   <= OccProbRst;
      empty_int_q  <= EmptyIntRst;
      occ_int_q    <= OccIntRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFusionMode: mode_q       <= cfg_data_i[1:0];
        CfgEmptyProb:  empty_prob_q <= cfg_data_i;
        CfgOccProb:    occ_prob_q   <= cfg_data_i;
        CfgEmptyInt:   empty_int_q  <= cfg_data_i[LevelW-1:0];
        CfgOccInt:     occ_int_q    <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic [ClrW-1:0] clr_q;
  logic            clearing;

  assign clearing = (clr_q < ClrW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Pipeline registers
  acc_t  a_q;
  prod_t b_q;
  div_t  dv_q [0:DivSteps];

  // Interlock on an address still in flight
  logic hazard;
  always_comb begin
    hazard = (a_q.valid && a_q.addr == cell_index_i) ||
             (b_q.ctl.valid && b_q.ctl.addr == cell_index_i);
    for (int k = 0; k <= DivSteps; k++) begin
      if (dv_q[k].ctl.valid && dv_q[k].ctl.addr == cell_index_i) hazard = 1'b1;
    end
  end

  logic accept;
  assign busy   = clearing || hazard;
  assign accept = start && !busy;

  // Grid memories
  logic [ProbW-1:0]         prob_mem  [0:CellStore-1];
  logic signed [LevelW-1:0] level_mem [0:CellStore-1];
  logic [ProbW-1:0]         prob_rd_q;
  logic signed [LevelW-1:0] level_rd_q;

  logic                     prob_we, level_we;
  logic [CellAddrW-1:0]     wr_addr;
  logic [ProbW-1:0]         prob_wd;
  logic signed [LevelW-1:0] level_wd;

  always_ff @(posedge clk_i) begin
    if (prob_we) begin
      prob_mem[wr_addr] <= prob_wd;
    end
    if (level_we) begin
      level_mem[wr_addr] <= level_wd;
    end
    prob_rd_q  <= prob_mem[cell_index_i];
    level_rd_q <= level_mem[cell_index_i];
  end

  // Accept stage: sigmoid lookup alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else begin
      a_q.valid    <= accept;
      a_q.addr     <= cell_index_i;
      a_q.in_range <= (longint'(cell_index_i) < Cells);
      a_q.ev       <= evidence_i;
      a_q.pn       <= sigmoid(evidence_i);
    end
  end

  // Decode stage: per-mode results and pool products
  ctl_t b_ctl;
  always_comb begin
    b_ctl          = '0;
    b_ctl.valid    = a_q.valid;
    b_ctl.addr     = a_q.addr;
    b_ctl.cls      = ClsNone;
    b_ctl.prob     = HalfProb;
    b_ctl.level    = 9'sd0;
    if (a_q.in_range) begin
      b_ctl.prob  = prob_rd_q;
      b_ctl.level = level_rd_q;
      case (mode_q)
        ModePool: begin
          b_ctl.cls     = ClsProb;
          b_ctl.use_div = 1'b1;
          b_ctl.we_prob = 1'b1;
        end
        ModeMax: begin
          b_ctl.cls     = ClsProb;
          b_ctl.we_prob = 1'b1;
          b_ctl.prob    = fuse_max(a_q.pn, prob_rd_q);
        end
        ModeLevel: begin
          b_ctl.cls      = ClsLevel;
          b_ctl.we_level = 1'b1;
          b_ctl.level    = fuse_int(a_q.ev, level_rd_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else begin
      b_q.ctl <= b_ctl;
      b_q.num <= ProdW'(a_q.pn * prob_rd_q);
      b_q.oth <= ProdW'((17'd65536 - 17'(a_q.pn)) * (17'd65536 - 17'(prob_rd_q)));
    end
  end

  // Divider setup: dividend = num * 2^16 + den / 2
  logic [ProdW-1:0]          den;
  logic [ProdW+QuotW-2:0]    dividend;
  assign den      = b_q.num + b_q.oth;
  assign dividend = {b_q.num[ProdW-3:0], 16'd0} + (ProdW+QuotW-1)'(den >> 1);

  // Restoring divider, one quotient bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) begin
        dv_q[k] <= '0;
      end
    end else begin
      dv_q[0].ctl  <= b_q.ctl;
      dv_q[0].rem  <= ProdW'(dividend[ProdW+QuotW-2:QuotW]);
      dv_q[0].nlow <= dividend[QuotW-1:0];
      dv_q[0].den  <= den;
      dv_q[0].quot <= '0;
      for (int k = 1; k <= DivSteps; k++) begin
        logic [ProdW:0] t;
        logic           qb;
        t  = {dv_q[k-1].rem, dv_q[k-1].nlow[QuotW-1]};
        qb = (t >= {1'b0, dv_q[k-1].den});
        dv_q[k].ctl  <= dv_q[k-1].ctl;
        dv_q[k].den  <= dv_q[k-1].den;
        dv_q[k].nlow <= {dv_q[k-1].nlow[QuotW-2:0], 1'b0};
        dv_q[k].quot <= {dv_q[k-1].quot[QuotW-2:0], qb};
        dv_q[k].rem  <= qb ? ProdW'(t - {1'b0, dv_q[k-1].den}) : ProdW'(t);
      end
    end
  end

  // Write-back and classification
  ctl_t                     f_ctl;
  logic [ProbW-1:0]         f_prob;
  logic signed [MapW-1:0]   f_map;

  assign f_ctl = dv_q[DivSteps].ctl;

  always_comb begin
    f_prob = f_ctl.prob;
    if (f_ctl.use_div) begin
      if (dv_q[DivSteps].quot == '0) f_prob = 16'd1;
      else if (dv_q[DivSteps].quot[QuotW-1]) f_prob = 16'd65535;
      else f_prob = dv_q[DivSteps].quot[ProbW-1:0];
    end
    case (f_ctl.cls)
      ClsProb: begin
        if (f_prob < empty_prob_q) f_map = MapEmpty;
        else if (f_prob > occ_prob_q) f_map = MapOcc;
        else f_map = MapUnknown;
      end
      ClsLevel: begin
        if (f_ctl.level < empty_int_q) f_map = MapEmpty;
        else if (f_ctl.level > occ_int_q) f_map = MapOcc;
        else f_map = MapUnknown;
      end
      default: f_map = MapUnknown;
    endcase
  end

  // Memory write mux: clearing pass or pipeline write-back
  always_comb begin
    if (clearing) begin
      prob_we  = 1'b1;
      level_we = 1'b1;
      wr_addr  = clr_q[CellAddrW-1:0];
      prob_wd  = HalfProb;
      level_wd = 9'sd0;
    end else begin
      prob_we  = f_ctl.valid && f_ctl.we_prob;
      level_we = f_ctl.valid && f_ctl.we_level;
      wr_addr  = f_ctl.addr;
      prob_wd  = f_prob;
      level_wd = f_ctl.level;
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= f_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_addr_out_o <= f_ctl.addr;
    map_value_o     <= f_map;
    fused_prob_o    <= f_prob;
    fused_level_o   <= f_ctl.level;
  end

endmodule
